### hdl/smbst_pkg.sv
`default_nettype none

package smbst_pkg;

	// Width of the byte offset and structure start counters; they wrap.
	localparam int OFFSET_BITS = 16;
	// One more bit for the offset compares, so that a sum cannot wrap.
	localparam int CMP_W = OFFSET_BITS + 1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TYPE    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_STRUCTURES = 2'd2;

	localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;
	// Header bytes: type, formatted length, handle low, handle high.
	localparam logic [7:0] HEADER_BYTES = 8'd4;

	localparam logic EV_MATCH = 1'b0;
	localparam logic EV_END   = 1'b1;

	localparam logic [1:0] REASON_END_TYPE  = 2'd0;
	localparam logic [1:0] REASON_LENGTH    = 2'd1;
	localparam logic [1:0] REASON_COUNT     = 2'd2;
	localparam logic [1:0] REASON_MALFORMED = 2'd3;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TYPE,
		PH_LEN,
		PH_HANDLE_LO,
		PH_HANDLE_HI,
		PH_BODY,
		PH_STRINGS
	} phase_t;

	typedef struct packed {
		logic [7:0]  target_type;
		logic [15:0] table_length;
		logic [15:0] max_structures;
	} cfg_regs_t;

	typedef struct packed {
		phase_t                 phase;
		logic [OFFSET_BITS-1:0] byte_offset;
		logic [OFFSET_BITS-1:0] structure_start;
		logic [15:0]            structure_count;
		logic [7:0]             formatted_length;
		logic                   previous_was_zero;
		logic                   walk_done;
	} walk_state_t;

	typedef struct packed {
		logic        event_kind;
		logic [15:0] structure_number;
		logic [15:0] start_offset;
		logic [1:0]  end_reason;
	} event_t;

endpackage

`default_nettype wire

### hdl/smbst_ifs.sv
`default_nettype none

interface smbst_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface smbst_event_if;
	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [15:0] structure_number;
	logic [15:0] start_offset;
	logic [1:0]  end_reason;

	modport source (output valid, output event_kind, output structure_number,
		output start_offset, output end_reason, input ready);
	modport sink (input valid, input event_kind, input structure_number,
		input start_offset, input end_reason, output ready);
endinterface

interface smbst_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [15:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### hdl/smbst_step.sv
`default_nettype none

module smbst_step
	import smbst_pkg::*;
(
	input  var cfg_regs_t   cfg_regs,
	input  var walk_state_t cur,
	input  var logic [7:0]  data_byte,
	input  var logic        first_byte,
	output walk_state_t     nxt,
	output logic            res_valid,
	output event_t          res
);

	walk_state_t eff;
	phase_t      nxt_phase;
	logic        nxt_done;

	logic                   rs_len_end;
	logic                   rs_stop;
	logic                   active;
	logic [OFFSET_BITS-1:0] pos_next;
	logic [CMP_W-1:0]       pos_inc_w;
	logic [CMP_W-1:0]       tl_w;
	logic                   len_small;
	logic                   len_past;
	logic                   body_last;
	logic                   dbl_zero;
	logic                   next_len_end;
	logic                   count_end;
	logic                   table_last;
	logic [15:0]            count_inc;
	logic                   is_target;
	logic                   is_eot;

	// Restart view of the state on a first byte.
	always_comb begin
		eff = cur;
		if (first_byte) begin
			eff.phase             = PH_TYPE;
			eff.byte_offset       = '0;
			eff.structure_start   = '0;
			eff.structure_count   = '0;
			eff.formatted_length  = '0;
			eff.previous_was_zero = 1'b0;
			eff.walk_done         = 1'b0;
		end
	end

	assign tl_w         = CMP_W'(cfg_regs.table_length);
	assign rs_len_end   = tl_w <= CMP_W'(HEADER_BYTES);
	assign rs_stop      = first_byte && (rs_len_end || cfg_regs.max_structures == '0);
	assign active       = !rs_stop && (first_byte || !cur.walk_done);
	assign pos_next     = eff.byte_offset + 1'b1;
	assign pos_inc_w    = CMP_W'(eff.byte_offset) + CMP_W'(1);
	assign len_small    = data_byte < HEADER_BYTES;
	assign len_past     = CMP_W'(eff.structure_start) + CMP_W'(data_byte) + CMP_W'(1) >= tl_w;
	assign body_last    = pos_inc_w >=
		CMP_W'(eff.structure_start) + CMP_W'(eff.formatted_length);
	assign dbl_zero     = data_byte == 8'd0 && eff.previous_was_zero;
	assign next_len_end = CMP_W'(pos_next) + CMP_W'(HEADER_BYTES) >= tl_w;
	assign count_end    = eff.structure_count >= cfg_regs.max_structures;
	assign table_last   = pos_inc_w >= tl_w;
	assign count_inc    = eff.structure_count + 16'd1;
	assign is_target    = data_byte == cfg_regs.target_type;
	assign is_eot       = data_byte == END_OF_TABLE_TYPE;

	// Next phase and done flag.
	always_comb begin
		nxt_phase = eff.phase;
		nxt_done  = eff.walk_done;
		if (rs_stop) begin
			nxt_phase = PH_IDLE;
			nxt_done  = 1'b1;
		end else if (active) begin
			unique case (eff.phase)
				PH_TYPE: begin
					if (!is_target && is_eot) begin
						nxt_phase = PH_IDLE;
						nxt_done  = 1'b1;
					end else begin
						nxt_phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (len_small || len_past) begin
						nxt_phase = PH_IDLE;
						nxt_done  = 1'b1;
					end else begin
						nxt_phase = PH_HANDLE_LO;
					end
				end
				PH_HANDLE_LO: nxt_phase = PH_HANDLE_HI;
				PH_HANDLE_HI: begin
					nxt_phase = (eff.formatted_length == HEADER_BYTES) ? PH_STRINGS : PH_BODY;
				end
				PH_BODY: begin
					if (body_last)
						nxt_phase = PH_STRINGS;
				end
				PH_STRINGS: begin
					if (dbl_zero) begin
						if (next_len_end || count_end) begin
							nxt_phase = PH_IDLE;
							nxt_done  = 1'b1;
						end else begin
							nxt_phase = PH_TYPE;
						end
					end else if (table_last) begin
						nxt_phase = PH_IDLE;
						nxt_done  = 1'b1;
					end
				end
				default: begin
					nxt_phase = PH_IDLE;
					nxt_done  = 1'b1;
				end
			endcase
		end
	end

	// Counters and header fields.
	always_comb begin
		nxt           = eff;
		nxt.phase     = nxt_phase;
		nxt.walk_done = nxt_done;
		if (rs_stop || active)
			nxt.byte_offset = pos_next;
		if (active) begin
			case (eff.phase)
				PH_TYPE:      nxt.structure_count = count_inc;
				PH_LEN:       nxt.formatted_length = data_byte;
				PH_HANDLE_HI: nxt.previous_was_zero = 1'b0;
				PH_BODY: begin
					if (body_last)
						nxt.previous_was_zero = 1'b0;
				end
				PH_STRINGS: begin
					if (dbl_zero) begin
						nxt.structure_start   = pos_next;
						nxt.previous_was_zero = 1'b0;
					end else if (!table_last) begin
						nxt.previous_was_zero = data_byte == 8'd0;
					end
				end
				default: ;
			endcase
		end
	end

	// Result of this byte, if any.
	always_comb begin
		res_valid            = 1'b0;
		res.event_kind       = EV_END;
		res.structure_number = eff.structure_count;
		res.start_offset     = '0;
		res.end_reason       = REASON_END_TYPE;
		if (rs_stop) begin
			res_valid      = 1'b1;
			res.end_reason = rs_len_end ? REASON_LENGTH : REASON_COUNT;
		end else if (active) begin
			case (eff.phase)
				PH_TYPE: begin
					res.structure_number = count_inc;
					if (is_target) begin
						res_valid        = 1'b1;
						res.event_kind   = EV_MATCH;
						res.start_offset = 16'(eff.structure_start);
					end else if (is_eot) begin
						res_valid = 1'b1;
					end
				end
				PH_LEN: begin
					if (len_small) begin
						res_valid      = 1'b1;
						res.end_reason = REASON_MALFORMED;
					end else if (len_past) begin
						res_valid      = 1'b1;
						res.end_reason = REASON_LENGTH;
					end
				end
				PH_STRINGS: begin
					if (dbl_zero) begin
						if (next_len_end) begin
							res_valid      = 1'b1;
							res.end_reason = REASON_LENGTH;
						end else if (count_end) begin
							res_valid      = 1'b1;
							res.end_reason = REASON_COUNT;
						end
					end else if (table_last) begin
						res_valid      = 1'b1;
						res.end_reason = REASON_LENGTH;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/smbios_structure_table_walker.sv
// Channel   Role    Handshake      Carries
// bytes     sink    valid/ready    data_byte, first_byte (table bytes in address order)
// events    source  valid/ready    event_kind, structure_number, start_offset, end_reason
// cfg       sink    valid/ready    reg_index, wdata (ready is always high)
//
// One table byte is taken every cycle unless a held event waits on events.ready;
// smbst_step does the per-byte walk update between the walk state and event registers.
// An event shows on the events channel in the cycle after the byte that caused it is taken.
// Reset clears the walk (done, idle) and the three registers to zero.
// A held event stalls the byte channel only while events.ready is low;
// when it is taken, a new byte is accepted in the same cycle.
`default_nettype none

module smbios_structure_table_walker
	import smbst_pkg::*;
(
	input  var logic       clk,
	input  var logic       arst_n,
	smbst_byte_if.sink     bytes,
	smbst_event_if.source  events,
	smbst_cfg_if.sink      cfg
);

	cfg_regs_t   cfg_q;
	walk_state_t walk_q;
	walk_state_t walk_nxt;
	event_t      ev_q;
	event_t      ev_nxt;
	logic        ev_valid_q;
	logic        ev_nxt_valid;
	logic        byte_req;

	// Configuration: always ready, write the register named by the index.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_TARGET_TYPE:    cfg_q.target_type    <= cfg.wdata[7:0];
				REG_TABLE_LENGTH:   cfg_q.table_length   <= cfg.wdata;
				REG_MAX_STRUCTURES: cfg_q.max_structures <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Take a byte whenever the event register is free or being emptied.
	assign bytes.ready = !ev_valid_q || events.ready;
	assign byte_req    = bytes.valid && bytes.ready;

	smbst_step u_step (
		.cfg_regs   (cfg_q),
		.cur        (walk_q),
		.data_byte  (bytes.data_byte),
		.first_byte (bytes.first_byte),
		.nxt        (walk_nxt),
		.res_valid  (ev_nxt_valid),
		.res        (ev_nxt)
	);

	// Walk state: advance only on an accepted byte request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q.phase             <= PH_IDLE;
			walk_q.byte_offset       <= '0;
			walk_q.structure_start   <= '0;
			walk_q.structure_count   <= '0;
			walk_q.formatted_length  <= '0;
			walk_q.previous_was_zero <= 1'b0;
			walk_q.walk_done         <= 1'b1;
		end else if (byte_req) begin
			walk_q <= walk_nxt;
		end
	end

	// Event register: load on a byte that yields an event, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (byte_req) begin
			ev_valid_q <= ev_nxt_valid;
		end else if (events.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	// Hold the payload while it waits; no reset needed.
	always_ff @(posedge clk) begin
		if (byte_req && ev_nxt_valid)
			ev_q <= ev_nxt;
	end

	assign events.valid            = ev_valid_q;
	assign events.event_kind       = ev_q.event_kind;
	assign events.structure_number = ev_q.structure_number;
	assign events.start_offset     = ev_q.start_offset;
	assign events.end_reason       = ev_q.end_reason;

endmodule

`default_nettype wire
